[hdl/cbm_pkg.sv]
// Shared types and constants for the cartridge bank mapper.
// Used by cbm_front, cbm_queue, cbm_back and the top level.
`default_nettype none
package cbm_pkg;

	localparam int DEF_MAX_PRG_BANKS = 64;
	localparam int DEF_MAX_CHR_BANKS = 128;
	localparam int QUEUE_DEPTH       = 2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 8;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CHR_WRITE = 2'd2;

	// register port decode: (address & MAP_REG_MASK)
	localparam logic [15:0] MAP_REG_MASK   = 16'hE001;
	localparam logic [15:0] MAP_REG_SELECT = 16'h8000;
	localparam logic [15:0] MAP_REG_LOAD   = 16'h8001;
	localparam logic [15:0] PPU_LIMIT      = 16'h3F00;

	localparam logic [6:0] MASK_CHR2K = 7'h3E;
	localparam logic [6:0] MASK_CHR1K = 7'h3F;
	localparam logic [6:0] SET_CHR1K  = 7'h40;
	localparam logic [6:0] MASK_PRG   = 7'h0F;

	typedef logic [6:0] bank_reg_t;
	localparam bank_reg_t BANK_RESET [8] = '{7'h00, 7'h02, 7'h44, 7'h45,
		7'h46, 7'h47, 7'h00, 7'h01};

	typedef enum logic [1:0] {
		OP_CPU_RD = 2'd0,
		OP_CPU_WR = 2'd1,
		OP_PPU_RD = 2'd2,
		OP_PPU_WR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_PRG  = 2'd1,
		TGT_CHR  = 2'd2,
		TGT_NT   = 2'd3
	} target_t;

	// one classified access, front to back
	typedef struct packed {
		target_t     kind;
		logic [7:0]  bank;     // raw bank before wrap
		logic [7:0]  divisor;  // clamped bank count, nonzero for PRG/CHR
		logic [12:0] low;      // in-bank offset, or full nametable offset
		logic        wr;
		logic [7:0]  data;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_DIV  = 2'd1,
		BK_HOLD = 2'd2
	} bk_state_t;

	function automatic bank_reg_t mask_bank(input logic [2:0] sel, input logic [7:0] d);
		bank_reg_t r;
		if (sel < 3'd2)
			r = d[6:0] & MASK_CHR2K;
		else if (sel < 3'd6)
			r = (d[6:0] & MASK_CHR1K) | SET_CHR1K;
		else
			r = d[6:0] & MASK_PRG;
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/cbm_front.sv]
// Front end: config registers, mapper register file, access classification.
// Depends on cbm_pkg; feeds cbm_queue.
`default_nettype none
module cbm_front #(
	parameter int MAX_PRG_BANKS = cbm_pkg::DEF_MAX_PRG_BANKS,
	parameter int MAX_CHR_BANKS = cbm_pkg::DEF_MAX_CHR_BANKS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write_en,
	input  wire logic [cbm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [cbm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          opcode,
	input  wire logic [15:0]                         bus_address,
	input  wire logic [7:0]                          write_byte,
	input  wire cbm_pkg::q_stat_t                    q_stat,
	output logic                                     push,
	output cbm_pkg::entry_t                          push_entry
);
	import cbm_pkg::*;

	localparam logic [8:0] PRG_MAX9 = 9'(MAX_PRG_BANKS);
	localparam logic [8:0] CHR_MAX9 = 9'(MAX_CHR_BANKS);

	logic [6:0] prg_count_q;
	logic [7:0] chr_count_q;
	logic       chr_wr_q;
	logic [2:0] sel_q;
	logic       upper_q;
	bank_reg_t  regs_q [8];

	op_t        op;
	logic [7:0] prg_cnt;
	logic [7:0] chr_cnt;
	logic [7:0] chr_bank;
	logic [6:0] chr_base;
	logic [2:0] chr_idx;
	logic       is_wr;
	logic       reg_write;

	assign op       = op_t'(opcode);
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready;
	assign is_wr    = (op == OP_PPU_WR);
	assign reg_write = push && (op == OP_CPU_WR) && bus_address[15];

	// counts above the supported maximum saturate
	assign prg_cnt = ({2'b0, prg_count_q} > PRG_MAX9) ? PRG_MAX9[7:0] : {1'b0, prg_count_q};
	assign chr_cnt = ({1'b0, chr_count_q} > CHR_MAX9) ? CHR_MAX9[7:0] : chr_count_q;

	// 2K slots at 0x0000/0x0800, 1K slots from 0x1000
	assign chr_base = bus_address[11] ? regs_q[1] : regs_q[0];
	assign chr_idx  = 3'({1'b0, bus_address[11:10]} + 3'd2);
	assign chr_bank = bus_address[12] ? {1'b0, regs_q[chr_idx]}
		: ({1'b0, chr_base} + {7'b0, bus_address[10]});

	always_comb begin
		push_entry = '0;
		push_entry.kind = TGT_NONE;
		case (op)
			OP_CPU_RD: begin
				if (bus_address[15] && (prg_cnt != 8'd0)) begin
					push_entry.kind    = TGT_PRG;
					push_entry.divisor = prg_cnt;
					push_entry.low     = bus_address[12:0];
					case (bus_address[14:13])
						2'b00:   push_entry.bank = {1'b0, regs_q[6]};
						2'b01:   push_entry.bank = {1'b0, regs_q[7]};
						2'b10:   push_entry.bank = (prg_cnt >= 8'd2) ? prg_cnt - 8'd2 : 8'd0;
						default: push_entry.bank = prg_cnt - 8'd1;
					endcase
				end
			end
			OP_CPU_WR: begin
				push_entry.kind = TGT_NONE;
			end
			OP_PPU_RD, OP_PPU_WR: begin
				// below 0x3F00 the top two address bits are zero; bit 13 picks
				// nametables, and 0x3000 mirrors 0x2000 by ignoring bit 12
				if (bus_address < PPU_LIMIT) begin
					if (bus_address[13]) begin
						push_entry.kind = TGT_NT;
						push_entry.low  = {2'b0, upper_q, bus_address[9:0]};
						push_entry.wr   = is_wr;
						push_entry.data = is_wr ? write_byte : 8'd0;
					end else if ((chr_cnt != 8'd0) && (!is_wr || chr_wr_q)) begin
						push_entry.kind    = TGT_CHR;
						push_entry.bank    = chr_bank;
						push_entry.divisor = chr_cnt;
						push_entry.low     = {3'b0, bus_address[9:0]};
						push_entry.wr      = is_wr;
						push_entry.data    = is_wr ? write_byte : 8'd0;
					end
				end
			end
			default: push_entry.kind = TGT_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q <= '0;
			chr_count_q <= '0;
			chr_wr_q    <= 1'b0;
			sel_q       <= '0;
			upper_q     <= 1'b0;
			for (int i = 0; i < 8; i++)
				regs_q[i] <= BANK_RESET[i];
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					CFG_PRG_COUNT: prg_count_q <= cfg_data[6:0];
					CFG_CHR_COUNT: chr_count_q <= cfg_data;
					CFG_CHR_WRITE: chr_wr_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (reg_write) begin
				upper_q <= write_byte[6];
				if ((bus_address & MAP_REG_MASK) == MAP_REG_SELECT)
					sel_q <= write_byte[2:0];
				else if ((bus_address & MAP_REG_MASK) == MAP_REG_LOAD)
					regs_q[sel_q] <= mask_bank(sel_q, write_byte);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/cbm_queue.sv]
// Short FIFO of classified accesses between front and back.
// Depends on cbm_pkg.
`default_nettype none
module cbm_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire cbm_pkg::entry_t   push_entry,
	input  wire logic              pop,
	output cbm_pkg::entry_t        head,
	output cbm_pkg::q_stat_t       stat
);
	import cbm_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(QUEUE_DEPTH);

	entry_t           mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (cnt_q == FULL);
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty)) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL) else $error("queue count out of range");

endmodule
`default_nettype wire

[hdl/cbm_back.sv]
// Back end: bank wrap by restoring remainder, offset assembly, output register.
// Depends on cbm_pkg; drains cbm_queue.
`default_nettype none
module cbm_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cbm_pkg::q_stat_t  q_stat,
	input  wire cbm_pkg::entry_t   head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             target,
	output logic [18:0]            mem_offset,
	output logic                   mem_write,
	output logic [7:0]             mem_data
);
	import cbm_pkg::*;

	bk_state_t  state_q, state_d;
	entry_t     ent_q;
	logic [7:0] rem_q;
	logic [7:0] dvd_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	logic [1:0] target_q;
	logic [18:0] offset_q;
	logic       wr_q;
	logic [7:0] data_q;

	logic [8:0]  trial;
	logic [8:0]  trial_sub;
	logic [7:0]  rem_next;
	logic        out_free;
	logic        load_out;
	logic [18:0] offset_d;
	logic        needs_wrap;

	assign out_free   = !out_valid_q || out_ready;
	assign needs_wrap = (head.kind == TGT_PRG) || (head.kind == TGT_CHR);

	// one quotient bit per cycle
	assign trial     = {rem_q, dvd_q[7]};
	assign trial_sub = trial - {1'b0, ent_q.divisor};
	assign rem_next  = (trial >= {1'b0, ent_q.divisor}) ? trial_sub[7:0] : trial[7:0];

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = needs_wrap ? BK_DIV : BK_HOLD;
				end
			end
			BK_DIV: begin
				if (cnt_q == 3'd0)
					state_d = BK_HOLD;
			end
			BK_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		case (ent_q.kind)
			TGT_PRG: offset_d = {rem_q[5:0], ent_q.low};
			TGT_CHR: offset_d = {2'b0, rem_q[6:0], ent_q.low[9:0]};
			TGT_NT:  offset_d = {8'b0, ent_q.low[10:0]};
			default: offset_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q <= head;
			rem_q <= '0;
			dvd_q <= head.bank;
			cnt_q <= 3'd7;
		end else if (state_q == BK_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[6:0], 1'b0};
			cnt_q <= cnt_q - 3'd1;
		end
		if (load_out) begin
			target_q <= ent_q.kind;
			offset_q <= offset_d;
			wr_q     <= ent_q.wr;
			data_q   <= ent_q.data;
		end
	end

	assign out_valid  = out_valid_q;
	assign target     = target_q;
	assign mem_offset = offset_q;
	assign mem_write  = wr_q;
	assign mem_data   = data_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (ent_q.divisor != 8'd0)) else $error("wrap by zero count");
	a_div_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (ent_q.kind == TGT_PRG || ent_q.kind == TGT_CHR))
		else $error("wrap on unbanked access");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_HOLD && (ent_q.kind == TGT_PRG || ent_q.kind == TGT_CHR))
		|-> (rem_q < ent_q.divisor)) else $error("bank not wrapped");

endmodule
`default_nettype wire

[hdl/cartridge_bank_mapper_with_mirroring_unit.sv]
// Top level of the cartridge bank mapper with one-screen mirroring.
// Depends on cbm_pkg, cbm_front, cbm_queue and cbm_back.
`default_nettype none
// Translates one CPU or PPU bus access per transfer into one memory access:
// target (none, program ROM, pattern memory, nametable RAM), byte offset,
// write strobe and write byte. CPU writes at 0x8000 and up update the bank
// registers and the one-screen select and always return a no-target result.
// The front accepts a transfer in the cycle it is offered as long as the
// two-entry queue has room, updating mapper state right there. The back pops
// one entry at a time: program and pattern accesses pass through the
// bit-serial remainder unit that wraps the bank by the bank count (pop,
// 8 remainder steps, output load); nametable and no-target accesses go
// from pop straight to output load. Results sit in an output register,
// so the back keeps working while a result waits for out_ready. Config writes
// (index 0 program bank count, 1 pattern bank count, 2 pattern RAM writable)
// take effect the next cycle and are only legal while the block is idle.
module cartridge_bank_mapper_with_mirroring_unit #(
	parameter int MAX_PRG_BANKS = cbm_pkg::DEF_MAX_PRG_BANKS,
	parameter int MAX_CHR_BANKS = cbm_pkg::DEF_MAX_CHR_BANKS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_write_en,
	input  wire logic [cbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [cbm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// access in
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       opcode,
	input  wire logic [15:0]                      bus_address,
	input  wire logic [7:0]                       write_byte,
	// translated access out
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [1:0]                            target,
	output logic [18:0]                           mem_offset,
	output logic                                  mem_write,
	output logic [7:0]                            mem_data
);
	import cbm_pkg::*;

	q_stat_t q_stat;
	entry_t  push_entry;
	entry_t  head;
	logic    push;
	logic    pop;

	// classify and apply register writes at transfer time
	cbm_front #(
		.MAX_PRG_BANKS (MAX_PRG_BANKS),
		.MAX_CHR_BANKS (MAX_CHR_BANKS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.bus_address  (bus_address),
		.write_byte   (write_byte),
		.q_stat       (q_stat),
		.push         (push),
		.push_entry   (push_entry)
	);

	// decouples front from the multi-cycle back
	cbm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	// bank wrap and offset assembly
	cbm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.target     (target),
		.mem_offset (mem_offset),
		.mem_write  (mem_write),
		.mem_data   (mem_data)
	);

endmodule
`default_nettype wire
